>>> hdl/i2cm_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
// Used by the input queue, the bus sequencer and the top level.
package i2cm_pkg;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd80;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam int         QUEUE_DEPTH_DEF = 4;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_PHASE_TICKS    = 1'b1
  } reg_idx_t;

  // Transaction kind.
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_START_HI  = 4'd1,
    S_START_LO  = 4'd2,
    S_TX_LOW    = 4'd3,
    S_TX_HIGH   = 4'd4,
    S_ACK_LOW   = 4'd5,
    S_ACK_HIGH  = 4'd6,
    S_RS_LOW    = 4'd7,
    S_RX_LOW    = 4'd8,
    S_RX_HIGH   = 4'd9,
    S_MN_LOW    = 4'd10,
    S_MN_HIGH   = 4'd11,
    S_STOP_LOW  = 4'd12,
    S_STOP_HIGH = 4'd13,
    S_STOP_END  = 4'd14
  } step_t;

  // One bus tick as it travels from the front queue to the sequencer.
  typedef struct packed {
    logic       cmd_valid;
    func_t      func;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // Bus configuration handed to the sequencer.
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] phase_ticks;
  } cfg_t;

endpackage

>>> hdl/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master: config registers, queue and sequencer.
// Depends on i2cm_pkg, i2cm_queue and i2cm_seq.
//
// Each input item is one bus tick and yields exactly one result item carrying the
// SCL/SDA levels for that tick plus busy, done, success and read data. The block
// takes one item per clock cycle while in_stall is low. A result is offered once the
// item has passed the input queue and the sequencer has registered its result, and
// it is held while out_stall is high. The sequencer does one tick item per cycle,
// waiting while a held result stalls it. A write or random read runs START, address
// and data bytes with ACK checks (a read also a repeated START), and STOP; each SCL
// phase lasts phase_ticks items. Configuration may be written only when no accepted
// item is still waiting for its result.
module i2c_eeprom_byte_master #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic        in_func,
  input  logic [7:0]  in_word_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_success,
  output logic [7:0]  out_read_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cm_pkg::*;

  logic [6:0] dev_addr_r;
  logic [7:0] phase_ticks_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  cfg_t       cfg;
  item_t      in_item, q_item;
  logic       q_valid, q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEV_ADDR_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEVICE_ADDRESS: dev_addr_r    <= cfg_pwdata[6:0];
        REG_PHASE_TICKS:    phase_ticks_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEVICE_ADDRESS: cfg_prdata = {25'd0, dev_addr_r};
      REG_PHASE_TICKS:    cfg_prdata = {24'd0, phase_ticks_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.device_address = dev_addr_r;
  assign cfg.phase_ticks    = phase_ticks_r;

  assign in_item.cmd_valid    = in_cmd_valid;
  assign in_item.func         = func_t'(in_func);
  assign in_item.word_address = in_word_address;
  assign in_item.write_data   = in_write_data;
  assign in_item.sda_in       = in_sda_in;

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  i2cm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_success   (out_success),
    .out_read_data (out_read_data)
  );

endmodule

>>> hdl/i2cm_queue.sv
// Front part: accepts tick items into a short FIFO ahead of the sequencer.
// Depends on i2cm_pkg for the item type.
module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  i2cm_pkg::item_t in_item,
  output logic            q_valid,
  output i2cm_pkg::item_t q_item,
  input  logic            q_pop
);
  import i2cm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

>>> hdl/i2cm_seq.sv
// Back part: I2C bus sequencer, driven one tick item at a time, with the result register.
// Depends on i2cm_pkg for the step, item and config types.
module i2cm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  i2cm_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  i2cm_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_scl_level,
  output logic            out_sda_drive,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_success,
  output logic [7:0]      out_read_data
);
  import i2cm_pkg::*;

  step_t       step_r, step_nxt, st;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shifter_r, shifter_nxt, sh;
  logic [7:0]  phase_r, phase_nxt;
  func_t       kind_r, kind_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  bidx_r, bidx_nxt, bidx_inc;
  logic        ok_r, ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        scl_r, sda_r, busy_r, done_r, succ_r;
  logic [7:0]  rdata_r;
  logic        scl, sda, done, succ;
  logic [7:0]  rdata;
  logic [7:0]  limit;
  logic [8:0]  cnt;
  logic        fire;

  function automatic logic [7:0] byte_sel(input logic [6:0] dev, input logic [1:0] bi,
                                          input func_t k, input logic [7:0] a,
                                          input logic [7:0] d);
    logic [7:0] dev_b;
    dev_b = {dev, 1'b0};
    if (bi == 2'd0) begin
      return dev_b;
    end else if (bi == 2'd1) begin
      return a;
    end else begin
      return (k == FUNC_READ) ? {dev, 1'b1} : d;
    end
  endfunction

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;
  assign limit = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

  always_comb begin
    st  = step_r;
    sh  = shifter_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    bidx_nxt      = bidx_r;
    ok_nxt        = ok_r;
    bit_count_nxt = bit_count_r;
    phase_nxt     = phase_r;
    // A command only starts from idle; later commands are ignored.
    if (step_r == S_IDLE && q_item.cmd_valid) begin
      kind_nxt      = q_item.func;
      addr_nxt      = q_item.word_address;
      data_nxt      = q_item.write_data;
      bidx_nxt      = 2'd0;
      ok_nxt        = 1'b0;
      bit_count_nxt = 4'd0;
      phase_nxt     = 8'd0;
      st            = S_START_HI;
    end
    step_nxt    = st;
    shifter_nxt = sh;
    bidx_inc    = bidx_nxt + 2'd1;

    scl = 1'b1;
    sda = 1'b1;
    case (st)
      S_START_LO:  sda = 1'b0;
      S_TX_LOW: begin
        scl = 1'b0;
        sda = sh[7];
      end
      S_TX_HIGH:   sda = sh[7];
      S_ACK_LOW, S_RS_LOW, S_RX_LOW, S_MN_LOW: scl = 1'b0;
      S_STOP_LOW: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      S_STOP_HIGH: sda = 1'b0;
      default: ;
    endcase

    done  = 1'b0;
    succ  = 1'b0;
    rdata = 8'd0;
    cnt   = {1'b0, phase_nxt} + 9'd1;
    if (st != S_IDLE) begin
      if (cnt >= {1'b0, limit}) begin
        phase_nxt = 8'd0;
        case (st)
          S_START_HI: step_nxt = S_START_LO;
          S_START_LO: begin
            shifter_nxt   = byte_sel(cfg.device_address, bidx_nxt, kind_nxt, addr_nxt,
                                     data_nxt);
            bit_count_nxt = 4'd0;
            step_nxt      = S_TX_LOW;
          end
          S_TX_LOW:   step_nxt = S_TX_HIGH;
          S_TX_HIGH: begin
            shifter_nxt = {sh[6:0], 1'b0};
            if (bit_count_nxt == 4'd7) begin
              bit_count_nxt = 4'd0;
              step_nxt      = S_ACK_LOW;
            end else begin
              bit_count_nxt = bit_count_nxt + 4'd1;
              step_nxt      = S_TX_LOW;
            end
          end
          S_ACK_LOW:  step_nxt = S_ACK_HIGH;
          S_ACK_HIGH: begin
            if (q_item.sda_in) begin
              // slave NACK
              ok_nxt   = 1'b0;
              step_nxt = S_STOP_LOW;
            end else begin
              bidx_nxt = bidx_inc;
              if (kind_nxt == FUNC_WRITE && bidx_inc == 2'd3) begin
                ok_nxt   = 1'b1;
                step_nxt = S_STOP_LOW;
              end else if (kind_nxt == FUNC_READ && bidx_inc == 2'd2) begin
                step_nxt = S_RS_LOW;
              end else if (kind_nxt == FUNC_READ && bidx_inc == 2'd3) begin
                shifter_nxt   = 8'd0;
                bit_count_nxt = 4'd0;
                step_nxt      = S_RX_LOW;
              end else begin
                shifter_nxt   = byte_sel(cfg.device_address, bidx_inc, kind_nxt,
                                         addr_nxt, data_nxt);
                bit_count_nxt = 4'd0;
                step_nxt      = S_TX_LOW;
              end
            end
          end
          S_RS_LOW:   step_nxt = S_START_HI;
          S_RX_LOW:   step_nxt = S_RX_HIGH;
          S_RX_HIGH: begin
            shifter_nxt = {sh[6:0], q_item.sda_in};
            if (bit_count_nxt == 4'd7) begin
              bit_count_nxt = 4'd0;
              step_nxt      = S_MN_LOW;
            end else begin
              bit_count_nxt = bit_count_nxt + 4'd1;
              step_nxt      = S_RX_LOW;
            end
          end
          S_MN_LOW:   step_nxt = S_MN_HIGH;
          S_MN_HIGH: begin
            ok_nxt   = 1'b1;
            step_nxt = S_STOP_LOW;
          end
          S_STOP_LOW:  step_nxt = S_STOP_HIGH;
          S_STOP_HIGH: step_nxt = S_STOP_END;
          default: begin
            done     = 1'b1;
            succ     = ok_nxt;
            rdata    = (ok_nxt && kind_nxt == FUNC_READ) ? sh : 8'd0;
            step_nxt = S_IDLE;
          end
        endcase
      end else begin
        phase_nxt = cnt[7:0];
      end
    end

    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      bit_count_r <= 4'd0;
      shifter_r   <= 8'd0;
      phase_r     <= 8'd0;
      kind_r      <= FUNC_WRITE;
      addr_r      <= 8'd0;
      data_r      <= 8'd0;
      bidx_r      <= 2'd0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        step_r      <= step_nxt;
        bit_count_r <= bit_count_nxt;
        shifter_r   <= shifter_nxt;
        phase_r     <= phase_nxt;
        kind_r      <= kind_nxt;
        addr_r      <= addr_nxt;
        data_r      <= data_nxt;
        bidx_r      <= bidx_nxt;
        ok_r        <= ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_r   <= scl;
      sda_r   <= sda;
      busy_r  <= (step_nxt != S_IDLE);
      done_r  <= done;
      succ_r  <= succ;
      rdata_r <= rdata;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = scl_r;
  assign out_sda_drive = sda_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_success   = succ_r;
  assign out_read_data = rdata_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !busy_r)
    else $error("result marks done while still busy");

  a_rdata_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rdata_r != 8'd0 |-> done_r && succ_r)
    else $error("read data shown without a successful finish");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done |=> step_r == S_IDLE)
    else $error("sequencer not idle after finishing");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r < 4'd8)
    else $error("bit counter out of byte range");

endmodule
